FILE: design/cbd_pkg.sv
// Shared types and constants for the CPU bus decoder with sprite DMA.
// Used by cbd_decode and cpu_bus_decode_with_sprite_dma. No dependencies.
`default_nettype none

package cbd_pkg;

  typedef enum logic [1:0] {
    OP_READ    = 2'd0,
    OP_WRITE   = 2'd1,
    OP_TICK    = 2'd2,
    OP_BUTTONS = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    TGT_NONE = 2'd0,
    TGT_PPU  = 2'd1,
    TGT_APU  = 2'd2,
    TGT_CART = 2'd3
  } target_e;

  typedef enum logic [2:0] {
    RGN_RAM,
    RGN_PPU,
    RGN_APU,
    RGN_DMA,
    RGN_PAD1,
    RGN_PAD2,
    RGN_CART,
    RGN_NONE
  } region_e;

  localparam logic [15:0] PPU_BASE    = 16'h2000;
  localparam logic [15:0] APU_BASE    = 16'h4000;
  localparam logic [15:0] APU_LAST    = 16'h4013;
  localparam logic [15:0] DMA_REG     = 16'h4014;
  localparam logic [15:0] APU_STATUS  = 16'h4015;
  localparam logic [15:0] PAD1_REG    = 16'h4016;
  localparam logic [15:0] PAD2_REG    = 16'h4017;
  localparam logic [15:0] CART_BASE   = 16'h4020;

  localparam logic [2:0]  PHASE_CPU_A = 3'd0;
  localparam logic [2:0]  PHASE_CPU_B = 3'd3;
  localparam logic [2:0]  PHASE_LAST  = 3'd5;

  localparam logic [7:0]  DMA_LAST_IDX = 8'hFF;

endpackage

`default_nettype wire

FILE: design/cbd_decode.sv
// Address decoder: maps a CPU bus address to a region and a work RAM index.
// Depends on cbd_pkg.
`default_nettype none

module cbd_decode #(
  parameter int RAM_BYTES = 2048
) (
  input  wire logic [15:0]                  addr_i,
  output cbd_pkg::region_e                  region_o,
  output logic [$clog2(RAM_BYTES)-1:0]      ram_idx_o
);

  localparam int IDX_W = $clog2(RAM_BYTES);

  // Mirror reduction: address below 0x2000, quotient below 32, so five
  // conditional subtracts of the scaled size give the remainder.
  function automatic logic [IDX_W-1:0] ram_mirror(input logic [12:0] a);
    logic [17:0] rem;
    rem = {5'd0, a};
    for (int k = 4; k >= 0; k--) begin
      if (rem >= (18'(RAM_BYTES) << k)) begin
        rem = rem - (18'(RAM_BYTES) << k);
      end
    end
    return rem[IDX_W-1:0];
  endfunction

  always_comb begin
    priority if (addr_i < cbd_pkg::PPU_BASE) begin
      region_o = cbd_pkg::RGN_RAM;
    end else if (addr_i < cbd_pkg::APU_BASE) begin
      region_o = cbd_pkg::RGN_PPU;
    end else if (addr_i <= cbd_pkg::APU_LAST || addr_i == cbd_pkg::APU_STATUS) begin
      region_o = cbd_pkg::RGN_APU;
    end else if (addr_i == cbd_pkg::DMA_REG) begin
      region_o = cbd_pkg::RGN_DMA;
    end else if (addr_i == cbd_pkg::PAD1_REG) begin
      region_o = cbd_pkg::RGN_PAD1;
    end else if (addr_i == cbd_pkg::PAD2_REG) begin
      region_o = cbd_pkg::RGN_PAD2;
    end else if (addr_i >= cbd_pkg::CART_BASE) begin
      region_o = cbd_pkg::RGN_CART;
    end else begin
      region_o = cbd_pkg::RGN_NONE;
    end
  end

  assign ram_idx_o = ram_mirror(addr_i[12:0]);

endmodule

`default_nettype wire

FILE: design/cpu_bus_decode_with_sprite_dma.sv
// Top level: CPU bus decode, work RAM, serial pads, sprite DMA sequencer.
// Depends on cbd_pkg and cbd_decode.
//
// channel | dir | tuser            | tdata
// s_axis  | in  | operation [1:0]  | address, write_data, ext_read_data, pad1, pad2
// m_axis  | out | ext_target [1:0] | read_data .. dma_busy (see port comments)
//
// One transaction in and one out per cycle while m_axis is not stalled; each
// passes the input register, then the result register with the work RAM read data.
// After reset the work RAM is cleared, one entry per cycle: s_axis_tready_o
// stays low until every entry has been cleared.
// A stalled result holds the result register; the input register still takes
// a transaction while the result register is free or being drained.
`default_nettype none

module cpu_bus_decode_with_sprite_dma #(
  parameter int RAM_BYTES = 2048
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // [15:0] address, [23:16] write_data, [31:24] ext_read_data,
  // [39:32] pad1_buttons, [47:40] pad2_buttons
  input  wire logic [47:0] s_axis_tdata_i,
  // [1:0] operation
  input  wire logic [1:0]  s_axis_tuser_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [7:0] read_data, [23:8] ext_address, [24] ext_write, [32:25] ext_write_data,
  // [33] cpu_step, [34] oam_write, [42:35] oam_index, [50:43] oam_data,
  // [51] dma_busy, [55:52] zero
  output logic [55:0]      m_axis_tdata_o,
  // [1:0] ext_target
  output logic [1:0]       m_axis_tuser_o
);

  localparam int IDX_W = $clog2(RAM_BYTES);

  // ---------------------------------------------------------------- control
  logic             clr_q;
  logic [IDX_W-1:0] clr_cnt_q;
  logic             a_valid_q, b_valid_q;
  logic             a_adv, a_fire, s_fire;

  assign a_adv           = !b_valid_q || m_axis_tready_i;
  assign a_fire          = a_valid_q && a_adv;
  assign s_axis_tready_o = !clr_q && (!a_valid_q || a_adv);
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;

  // ---------------------------------------------------------- input register
  cbd_pkg::op_e a_op_q;
  logic [15:0]  a_addr_q;
  logic [7:0]   a_wdata_q, a_edata_q, a_pad1_q, a_pad2_q;

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      a_op_q    <= cbd_pkg::op_e'(s_axis_tuser_i);
      a_addr_q  <= s_axis_tdata_i[15:0];
      a_wdata_q <= s_axis_tdata_i[23:16];
      a_edata_q <= s_axis_tdata_i[31:24];
      a_pad1_q  <= s_axis_tdata_i[39:32];
      a_pad2_q  <= s_axis_tdata_i[47:40];
    end
  end

  // ------------------------------------------------------------ block state
  logic [7:0] pad1_latch_q, pad2_latch_q, pad1_shift_q, pad2_shift_q;
  logic [7:0] pad1_latch_d, pad2_latch_d, pad1_shift_d, pad2_shift_d;
  logic [7:0] page_q, page_d, idx_q, idx_d, held_q;
  logic       running_q, running_d, sync_q, sync_d;
  logic [2:0] phase_q, phase_d;

  // ---------------------------------------------------------------- decode
  logic [15:0]      acc_addr;
  cbd_pkg::region_e region;
  logic [IDX_W-1:0] ram_idx;
  logic             ph_cpu, dma_act, dma_rd, is_rd;

  assign ph_cpu   = (phase_q == cbd_pkg::PHASE_CPU_A) || (phase_q == cbd_pkg::PHASE_CPU_B);
  assign dma_act  = (a_op_q == cbd_pkg::OP_TICK) && ph_cpu && running_q && !sync_q;
  assign dma_rd   = dma_act && (phase_q == cbd_pkg::PHASE_CPU_A);
  assign is_rd    = (a_op_q == cbd_pkg::OP_READ) || dma_rd;
  assign acc_addr = (a_op_q == cbd_pkg::OP_TICK) ? {page_q, idx_q} : a_addr_q;

  cbd_decode #(
    .RAM_BYTES (RAM_BYTES)
  ) u_decode (
    .addr_i    (acc_addr),
    .region_o  (region),
    .ram_idx_o (ram_idx)
  );

  // ------------------------------------------------------- stage A results
  logic              r_from_ram, r_step, r_oam, r_ewr;
  logic [7:0]        r_val, r_ewd, r_oidx;
  cbd_pkg::target_e  r_tgt;
  logic [15:0]       r_eaddr;
  logic              ram_we, ram_re;

  always_comb begin
    r_from_ram   = 1'b0;
    r_val        = '0;
    r_tgt        = cbd_pkg::TGT_NONE;
    r_eaddr      = '0;
    r_ewr        = 1'b0;
    r_ewd        = '0;
    r_step       = 1'b0;
    r_oam        = 1'b0;
    r_oidx       = '0;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    pad1_latch_d = pad1_latch_q;
    pad2_latch_d = pad2_latch_q;
    pad1_shift_d = pad1_shift_q;
    pad2_shift_d = pad2_shift_q;
    page_d       = page_q;
    idx_d        = idx_q;
    running_d    = running_q;
    sync_d       = sync_q;
    phase_d      = phase_q;

    if (is_rd) begin
      unique case (region)
        cbd_pkg::RGN_RAM: begin
          r_from_ram = 1'b1;
          ram_re     = 1'b1;
        end
        cbd_pkg::RGN_PPU: begin
          r_tgt   = cbd_pkg::TGT_PPU;
          r_eaddr = acc_addr;
          r_val   = a_edata_q;
        end
        cbd_pkg::RGN_APU: begin
          r_tgt   = cbd_pkg::TGT_APU;
          r_eaddr = acc_addr;
          r_val   = a_edata_q;
        end
        cbd_pkg::RGN_CART: begin
          r_tgt   = cbd_pkg::TGT_CART;
          r_eaddr = acc_addr;
          r_val   = a_edata_q;
        end
        cbd_pkg::RGN_PAD1: begin
          r_val        = {7'd0, pad1_shift_q[0]};
          pad1_shift_d = {1'b0, pad1_shift_q[7:1]};
        end
        cbd_pkg::RGN_PAD2: begin
          r_val        = {7'd0, pad2_shift_q[0]};
          pad2_shift_d = {1'b0, pad2_shift_q[7:1]};
        end
        default: begin
          r_val = '0;
        end
      endcase
    end

    unique case (a_op_q)
      cbd_pkg::OP_WRITE: begin
        unique case (region)
          cbd_pkg::RGN_RAM: ram_we = 1'b1;
          cbd_pkg::RGN_PPU: begin
            r_tgt   = cbd_pkg::TGT_PPU;
            r_eaddr = acc_addr;
            r_ewr   = 1'b1;
            r_ewd   = a_wdata_q;
          end
          // a write to the second pad address goes to the APU
          cbd_pkg::RGN_APU, cbd_pkg::RGN_PAD2: begin
            r_tgt   = cbd_pkg::TGT_APU;
            r_eaddr = acc_addr;
            r_ewr   = 1'b1;
            r_ewd   = a_wdata_q;
          end
          cbd_pkg::RGN_CART: begin
            r_tgt   = cbd_pkg::TGT_CART;
            r_eaddr = acc_addr;
            r_ewr   = 1'b1;
            r_ewd   = a_wdata_q;
          end
          cbd_pkg::RGN_DMA: begin
            page_d    = a_wdata_q;
            idx_d     = '0;
            running_d = 1'b1;
          end
          cbd_pkg::RGN_PAD1: begin
            pad1_shift_d = pad1_latch_q;
            pad2_shift_d = pad2_latch_q;
          end
          default: ram_we = 1'b0;
        endcase
      end
      cbd_pkg::OP_TICK: begin
        if (ph_cpu) begin
          if (!running_q) begin
            r_step = 1'b1;
          end else if (sync_q) begin
            if (phase_q == cbd_pkg::PHASE_CPU_B) sync_d = 1'b0;
          end else if (phase_q == cbd_pkg::PHASE_CPU_B) begin
            r_oam  = 1'b1;
            r_oidx = idx_q;
            idx_d  = idx_q + 8'd1;
            if (idx_q == cbd_pkg::DMA_LAST_IDX) begin
              running_d = 1'b0;
              sync_d    = 1'b1;
            end
          end
        end
        phase_d = (phase_q == cbd_pkg::PHASE_LAST) ? 3'd0 : phase_q + 3'd1;
      end
      cbd_pkg::OP_BUTTONS: begin
        pad1_latch_d = a_pad1_q;
        pad2_latch_d = a_pad2_q;
      end
      default: r_step = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pad1_latch_q <= '0;
      pad2_latch_q <= '0;
      pad1_shift_q <= '0;
      pad2_shift_q <= '0;
      page_q       <= '0;
      idx_q        <= '0;
      running_q    <= 1'b0;
      sync_q       <= 1'b1;
      phase_q      <= '0;
    end else if (a_fire) begin
      pad1_latch_q <= pad1_latch_d;
      pad2_latch_q <= pad2_latch_d;
      pad1_shift_q <= pad1_shift_d;
      pad2_shift_q <= pad2_shift_d;
      page_q       <= page_d;
      idx_q        <= idx_d;
      running_q    <= running_d;
      sync_q       <= sync_d;
      phase_q      <= phase_d;
    end
  end

  // --------------------------------------------------------------- work RAM
  logic [7:0]       mem [RAM_BYTES];
  logic [7:0]       ram_q;
  logic             mem_we;
  logic [IDX_W-1:0] mem_widx;
  logic [7:0]       mem_wdata;

  assign mem_we    = clr_q || (a_fire && ram_we);
  assign mem_widx  = clr_q ? clr_cnt_q : ram_idx;
  assign mem_wdata = clr_q ? 8'd0 : a_wdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_widx] <= mem_wdata;
    if (a_fire && ram_re) ram_q <= mem[ram_idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == IDX_W'(RAM_BYTES - 1)) clr_q <= 1'b0;
    end
  end

  // ------------------------------------------------------- result register
  logic             b_from_ram_q, b_dma_rd_q, b_ewr_q, b_step_q, b_oam_q, b_busy_q;
  logic [7:0]       b_val_q, b_ewd_q, b_oidx_q;
  cbd_pkg::target_e b_tgt_q;
  logic [15:0]      b_eaddr_q;
  logic [7:0]       rd_out, oam_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (s_fire) a_valid_q <= 1'b1;
      else if (a_fire) a_valid_q <= 1'b0;
      if (a_fire) b_valid_q <= 1'b1;
      else if (m_axis_tready_i) b_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_fire) begin
      b_from_ram_q <= r_from_ram;
      b_dma_rd_q   <= dma_rd;
      b_val_q      <= r_val;
      b_tgt_q      <= r_tgt;
      b_eaddr_q    <= r_eaddr;
      b_ewr_q      <= r_ewr;
      b_ewd_q      <= r_ewd;
      b_step_q     <= r_step;
      b_oam_q      <= r_oam;
      b_oidx_q     <= r_oidx;
      b_busy_q     <= running_d;
    end
  end

  assign rd_out = b_from_ram_q ? ram_q : b_val_q;

  // DMA fetch byte is captured while its transaction sits in the result stage;
  // the matching OAM write always follows several transactions later.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
    end else if (b_valid_q && b_dma_rd_q) begin
      held_q <= rd_out;
    end
  end

  assign oam_data        = b_oam_q ? held_q : 8'd0;
  assign m_axis_tvalid_o = b_valid_q;
  assign m_axis_tuser_o  = b_tgt_q;
  assign m_axis_tdata_o  = {4'd0, b_busy_q, oam_data, b_oidx_q, b_oam_q, b_step_q,
                            b_ewd_q, b_ewr_q, b_eaddr_q, rd_out};

endmodule

`default_nettype wire

FILE: design/cbd_checker.sv
// Port-level checks for cpu_bus_decode_with_sprite_dma, bound to the top.
// Depends on nothing but the top level's ports.
`default_nettype none

module cbd_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [55:0] m_axis_tdata_o,
  input wire logic [1:0]  m_axis_tuser_o
);

  logic out_xact;
  assign out_xact = m_axis_tvalid_o && m_axis_tready_i;

  // a granted CPU cycle means no DMA is left running
  a_step_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xact && m_axis_tdata_o[33] |-> !m_axis_tdata_o[51] && !m_axis_tdata_o[34])
    else $error("cpu_step with dma busy or oam write");

  // an OAM write carries no bus access
  a_oam_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xact && m_axis_tdata_o[34] |-> m_axis_tuser_o == 2'd0 && m_axis_tdata_o[7:0] == 8'd0)
    else $error("oam write with bus activity");

  // no external request means no external fields
  a_ext_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xact && m_axis_tuser_o == 2'd0 |-> m_axis_tdata_o[32:8] == 25'd0)
    else $error("external fields set without a target");

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("tvalid dropped while stalled");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("payload changed while stalled");

endmodule

bind cpu_bus_decode_with_sprite_dma cbd_checker u_cbd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

`default_nettype wire

FILE: tb/sv/bus_result_checker.sv
// Checker for the CPU bus decoder: watches both stream channels, predicts each
// result from its own RAM, pad and sprite DMA state, and compares field by field.
// Depends on cbd_pkg.
module bus_result_checker
  import cbd_pkg::*;
#(
  parameter int RAM_BYTES = 2048
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  // [15:0] address, [23:16] write_data, [31:24] ext_read_data,
  // [39:32] pad1_buttons, [47:40] pad2_buttons
  input  logic [47:0] s_axis_tdata_i,
  // [1:0] operation
  input  logic [1:0]  s_axis_tuser_i,
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  // [7:0] read_data, [23:8] ext_address, [24] ext_write, [32:25] ext_write_data,
  // [33] cpu_step, [34] oam_write, [42:35] oam_index, [50:43] oam_data,
  // [51] dma_busy, [55:52] zero
  input  logic [55:0] m_axis_tdata_i,
  // [1:0] ext_target
  input  logic [1:0]  m_axis_tuser_i,
  output int          errors_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Laid out MSB first so that {tuser, tdata} maps straight onto it.
  typedef struct packed {
    logic [1:0]  ext_target;
    logic [3:0]  zero_pad;
    logic        dma_busy;
    logic [7:0]  oam_data;
    logic [7:0]  oam_index;
    logic        oam_write;
    logic        cpu_step;
    logic [7:0]  ext_write_data;
    logic        ext_write;
    logic [15:0] ext_address;
    logic [7:0]  read_data;
  } bus_result_t;

  logic [7:0]  ram_img [RAM_BYTES];
  logic [7:0]  pad1_hold, pad2_hold, pad1_sreg, pad2_sreg;
  logic [7:0]  src_page, dma_idx, dma_byte;
  logic        dma_on, dma_align;
  logic [2:0]  phase;
  bus_result_t bus_results_q [$];
  int          mismatches = 0;

  function automatic void ext_req(inout bus_result_t r, input logic [1:0] tgt,
                                  input logic [15:0] a, input logic wr,
                                  input logic [7:0] wd);
    r.ext_target     = tgt;
    r.ext_address    = a;
    r.ext_write      = wr;
    r.ext_write_data = wr ? wd : 8'h00;
  endfunction

  function automatic logic [7:0] bus_fetch(input logic [15:0] a, input logic [7:0] ed,
                                           inout bus_result_t r);
    logic [7:0] v;
    v = 8'h00;
    if (a < PPU_BASE) begin
      v = ram_img[int'(a) % RAM_BYTES];
    end else if (a < APU_BASE) begin
      ext_req(r, TGT_PPU, a, 1'b0, 8'h00);
      v = ed;
    end else if (a <= APU_LAST || a == APU_STATUS) begin
      ext_req(r, TGT_APU, a, 1'b0, 8'h00);
      v = ed;
    end else if (a == PAD1_REG) begin
      v = {7'd0, pad1_sreg[0]};
      pad1_sreg = pad1_sreg >> 1;
    end else if (a == PAD2_REG) begin
      v = {7'd0, pad2_sreg[0]};
      pad2_sreg = pad2_sreg >> 1;
    end else if (a >= CART_BASE) begin
      ext_req(r, TGT_CART, a, 1'b0, 8'h00);
      v = ed;
    end
    return v;
  endfunction

  function automatic void bus_store(input logic [15:0] a, input logic [7:0] wd,
                                    inout bus_result_t r);
    if (a < PPU_BASE) begin
      ram_img[int'(a) % RAM_BYTES] = wd;
    end else if (a < APU_BASE) begin
      ext_req(r, TGT_PPU, a, 1'b1, wd);
    end else if (a == DMA_REG) begin
      // restart keeps the current sync state
      src_page = wd;
      dma_idx  = 8'h00;
      dma_on   = 1'b1;
    end else if (a <= APU_LAST || a == APU_STATUS || a == PAD2_REG) begin
      ext_req(r, TGT_APU, a, 1'b1, wd);
    end else if (a == PAD1_REG) begin
      pad1_sreg = pad1_hold;
      pad2_sreg = pad2_hold;
    end else if (a >= CART_BASE) begin
      ext_req(r, TGT_CART, a, 1'b1, wd);
    end
  endfunction

  function automatic void master_tick(input logic [7:0] ed, inout bus_result_t r);
    logic [7:0] v;
    if (phase == PHASE_CPU_A || phase == PHASE_CPU_B) begin
      if (!dma_on) begin
        r.cpu_step = 1'b1;
      end else if (dma_align) begin
        if (phase == PHASE_CPU_B) dma_align = 1'b0;
      end else if (phase == PHASE_CPU_A) begin
        v = bus_fetch({src_page, dma_idx}, ed, r);
        dma_byte    = v;
        r.read_data = v;
      end else begin
        r.oam_write = 1'b1;
        r.oam_index = dma_idx;
        r.oam_data  = dma_byte;
        if (dma_idx == DMA_LAST_IDX) begin
          dma_on    = 1'b0;
          dma_align = 1'b1;
        end
        dma_idx = dma_idx + 8'd1;
      end
    end
    phase = (phase >= PHASE_LAST) ? 3'd0 : phase + 3'd1;
  endfunction

  function automatic bus_result_t predict_bus_step(input logic [1:0] op,
                                                   input logic [47:0] d);
    bus_result_t r;
    logic [7:0]  v;
    r = '0;
    case (op)
      OP_READ: begin
        v = bus_fetch(d[15:0], d[31:24], r);
        r.read_data = v;
      end
      OP_WRITE: bus_store(d[15:0], d[23:16], r);
      OP_TICK:  master_tick(d[31:24], r);
      default: begin
        pad1_hold = d[39:32];
        pad2_hold = d[47:40];
      end
    endcase
    r.dma_busy = dma_on;
    return r;
  endfunction

  function automatic void cmp(input string name, input logic [15:0] want,
                              input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    bus_result_t got, want;
    if (!rst_ni) begin
      foreach (ram_img[i]) ram_img[i] = 8'h00;
      pad1_hold = 8'h00;
      pad2_hold = 8'h00;
      pad1_sreg = 8'h00;
      pad2_sreg = 8'h00;
      src_page  = 8'h00;
      dma_idx   = 8'h00;
      dma_byte  = 8'h00;
      dma_on    = 1'b0;
      dma_align = 1'b1;
      phase     = 3'd0;
      bus_results_q.delete();
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = {m_axis_tuser_i, m_axis_tdata_i};
        if (bus_results_q.size() == 0) begin
          $error("result transaction with no input pending");
          mismatches++;
        end else begin
          want = bus_results_q.pop_front();
          cmp("ext_target", 16'(want.ext_target), 16'(got.ext_target));
          cmp("read_data", 16'(want.read_data), 16'(got.read_data));
          cmp("ext_address", want.ext_address, got.ext_address);
          cmp("ext_write", 16'(want.ext_write), 16'(got.ext_write));
          cmp("ext_write_data", 16'(want.ext_write_data), 16'(got.ext_write_data));
          cmp("cpu_step", 16'(want.cpu_step), 16'(got.cpu_step));
          cmp("oam_write", 16'(want.oam_write), 16'(got.oam_write));
          cmp("oam_index", 16'(want.oam_index), 16'(got.oam_index));
          cmp("oam_data", 16'(want.oam_data), 16'(got.oam_data));
          cmp("dma_busy", 16'(want.dma_busy), 16'(got.dma_busy));
          cmp("zero_pad", 16'(want.zero_pad), 16'(got.zero_pad));
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i)
        bus_results_q.push_back(predict_bus_step(s_axis_tuser_i, s_axis_tdata_i));
    end
    errors_o  <= mismatches;
    pending_o <= bus_results_q.size();
  end

endmodule

FILE: tb/sv/tb_top.sv
// Testbench top for cpu_bus_decode_with_sprite_dma: clock, reset, bus and tick
// stimulus with bursty input and a stalling output side, and the verdict.
// Depends on cbd_pkg, the block and bus_result_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import cbd_pkg::*;

  localparam int RAM_BYTES      = 2048;
  localparam int WATCHDOG_LIMIT = 12000;
  localparam int DRAIN_CYCLES   = 8;
  // worst case ticks for one full transfer: sync wait plus 256 x 6
  localparam int DMA_TICKS      = 1545;

  logic        clk     = 1'b0;
  logic        rst_n   = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [47:0] s_data  = '0;
  logic [1:0]  s_user  = '0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [55:0] m_data;
  logic [1:0]  m_user;
  int          errors;
  int          pending;

  int          burst_left  = 0;
  int          idle_cycles = 0;
  int unsigned rx_cnt  = 0;
  int unsigned rx_mode = 0;
  int unsigned rx_span = 100;

  cpu_bus_decode_with_sprite_dma #(.RAM_BYTES(RAM_BYTES)) uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user)
  );

  bus_result_checker #(.RAM_BYTES(RAM_BYTES)) chk (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_i (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_i (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_i  (m_data),
    .m_axis_tuser_i  (m_user),
    .errors_o        (errors),
    .pending_o       (pending)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // receiver: switches to a random stall mode at the end of each randomly drawn span
  always @(posedge clk) begin
    if (rx_cnt >= rx_span) begin
      rx_cnt  <= 0;
      rx_mode <= $urandom_range(0, 3);
      rx_span <= $urandom_range(32, 256);
    end else begin
      rx_cnt <= rx_cnt + 1;
    end
    case (rx_mode)
      0:       m_ready <= 1'b1;
      1:       m_ready <= ($urandom_range(0, 3) != 0);
      2:       m_ready <= ($urandom_range(0, 3) == 0);
      default: m_ready <= rx_cnt[3];
    endcase
  end

  always @(posedge clk) begin
    if ((s_valid && s_ready) || (m_valid && m_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send(input op_e op, input logic [15:0] a, input logic [7:0] wd,
                      input logic [7:0] ed, input logic [7:0] p1, input logic [7:0] p2);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_valid <= 1'b1;
    s_user  <= op;
    s_data  <= {p2, p1, ed, wd, a};
    do @(posedge clk); while (!s_ready);
  endtask

  // hold off input until every predicted result has been taken
  task automatic drain();
    s_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic logic [15:0] rand_addr();
    case ($urandom_range(0, 5))
      0:       return 16'($urandom_range(0, 16'h1FFF));
      1:       return 16'($urandom_range(PPU_BASE, 16'h3FFF));
      2:       return 16'($urandom_range(APU_BASE, 16'h401F));
      3:       return ($urandom_range(0, 1) != 0) ? PAD1_REG : PAD2_REG;
      4:       return 16'($urandom_range(CART_BASE, 16'hFFFF));
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic send_random(input int tick_pct, input bit dma_ok, output op_e op);
    logic [15:0] a;
    int          pick;
    a = rand_addr();
    if ($urandom_range(0, 99) < tick_pct) begin
      op = OP_TICK;
    end else begin
      pick = $urandom_range(0, 9);
      op = (pick < 5) ? OP_READ : (pick < 9) ? OP_WRITE : OP_BUTTONS;
    end
    if (op == OP_WRITE) begin
      if (!dma_ok) begin
        while (a == DMA_REG) a = rand_addr();
      end else if ($urandom_range(0, 39) == 0) begin
        a = DMA_REG;
      end
    end
    send(op, a, 8'($urandom()), 8'($urandom()), 8'($urandom()), 8'($urandom()));
  endtask

  initial begin
    op_e op;
    int  ticks;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // pads: latch, load both shifters, shift each port separately
    send(OP_BUTTONS, 16'h0000, 8'h00, 8'h00, 8'hFF, 8'h00);
    send(OP_WRITE, PAD1_REG, 8'h00, 8'h00, 8'h00, 8'h00);
    send(OP_READ, PAD1_REG, 8'h00, 8'hFF, 8'h00, 8'h00);
    send(OP_READ, PAD2_REG, 8'h00, 8'hFF, 8'h00, 8'h00);
    send(OP_BUTTONS, 16'hFFFF, 8'hFF, 8'hFF, 8'h5A, 8'hA5);
    send(OP_WRITE, PAD1_REG, 8'hFF, 8'h00, 8'h00, 8'h00);
    send(OP_READ, PAD2_REG, 8'h00, 8'h00, 8'h00, 8'h00);
    // RAM and its mirrors
    send(OP_WRITE, 16'h0000, 8'hFF, 8'h00, 8'h00, 8'h00);
    send(OP_READ, 16'h1800, 8'h00, 8'h00, 8'h00, 8'h00);
    // external targets and the unmapped holes
    send(OP_READ, PPU_BASE, 8'h00, 8'hFF, 8'h00, 8'h00);
    send(OP_WRITE, 16'h3FFF, 8'hC3, 8'h00, 8'h00, 8'h00);
    send(OP_READ, APU_BASE, 8'h00, 8'h81, 8'h00, 8'h00);
    send(OP_WRITE, APU_LAST, 8'h7E, 8'h00, 8'h00, 8'h00);
    send(OP_READ, APU_STATUS, 8'h00, 8'h3C, 8'h00, 8'h00);
    send(OP_WRITE, PAD2_REG, 8'h40, 8'h00, 8'h00, 8'h00);
    send(OP_READ, DMA_REG, 8'h00, 8'hFF, 8'h00, 8'h00);
    send(OP_READ, 16'h401F, 8'h00, 8'hFF, 8'h00, 8'h00);
    send(OP_WRITE, 16'h4018, 8'hFF, 8'h00, 8'h00, 8'h00);
    send(OP_READ, CART_BASE, 8'h00, 8'hE7, 8'h00, 8'h00);
    send(OP_WRITE, 16'hFFFF, 8'h18, 8'h00, 8'h00, 8'h00);
    // DMA start, sync wait, first fetch, then a restart mid-transfer
    send(OP_WRITE, DMA_REG, 8'h00, 8'h00, 8'h00, 8'h00);
    repeat (8) send(OP_TICK, 16'h0000, 8'h00, 8'h99, 8'h00, 8'h00);
    send(OP_WRITE, DMA_REG, 8'h40, 8'h00, 8'h00, 8'h00);

    repeat (100) send_random(35, 1'b1, op);
    drain();

    // one transfer run to completion, from RAM, the I/O page or anywhere
    case ($urandom_range(0, 3))
      0:       send(OP_WRITE, DMA_REG, 8'($urandom_range(0, 8'h1F)), 8'h00, 8'h00, 8'h00);
      1:       send(OP_WRITE, DMA_REG, 8'h40, 8'h00, 8'h00, 8'h00);
      default: send(OP_WRITE, DMA_REG, 8'($urandom()), 8'h00, 8'h00, 8'h00);
    endcase
    ticks = 0;
    while (ticks < DMA_TICKS) begin
      send_random(93, 1'b0, op);
      if (op == OP_TICK) ticks++;
    end
    drain();

    repeat (100) send_random(35, 1'b1, op);

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

endmodule
